// ===== hw/rtl/cda_pkg.sv =====
// shared widths, result layout and calendar tables for the date analyzer
`default_nettype none

package cda_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int DOY_W   = 9;
   localparam int WDAY_W  = 3;
   localparam int SUM_W   = 15;
   localparam int QUOT_W  = 8;
   localparam int DIVD_W  = YEAR_W - 2;
   localparam int PROD_W  = 24;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 64;

   // floor(x / 25) as (x * RECIP_25) >> RECIP_SHIFT, exact for x below 4681
   localparam int RECIP_25    = 2622;
   localparam int RECIP_SHIFT = 16;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [WDAY_W-1:0] WDAY_FRIDAY   = 3'd5;
   localparam logic [WDAY_W-1:0] WDAY_SATURDAY = 3'd6;

   localparam logic [DOY_W-1:0] YEAR_DAYS      = 9'd365;
   localparam logic [DOY_W-1:0] LEAP_YEAR_DAYS = 9'd366;

   localparam logic [DAY_W-1:0] FEB_DAYS      = 5'd28;
   localparam logic [DAY_W-1:0] FEB_LEAP_DAYS = 5'd29;

   typedef struct packed {
      logic [YEAR_W-1:0]  next_year;
      logic [MONTH_W-1:0] next_month;
      logic [DAY_W-1:0]   next_day;
      logic [DOY_W-1:0]   days_to_year_end;
      logic [DOY_W-1:0]   day_of_year;
      logic [DAY_W-1:0]   days_to_month_end;
      logic [WDAY_W-1:0]  days_to_week_end;
      logic [DAY_W-1:0]   month_length;
      logic               is_business_day;
      logic               is_weekend;
      logic               is_end_of_week;
      logic [WDAY_W-1:0]  weekday;
   } rsp_type;

   // days in a month for a common year, zero outside january..december
   function automatic logic [DAY_W-1:0] month_days_base(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] d;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   d = 5'd30;
         4'd2:                                       d = FEB_DAYS;
         default:                                    d = 5'd0;
      endcase
      return d;
   endfunction

   // days before the first of the month in a common year; past december the whole year
   function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
      logic [DOY_W-1:0] d;
      case (m)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         4'd13, 4'd14, 4'd15: d = YEAR_DAYS;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   // floor(31 * shifted month / 12), january and february count as months 11 and 12
   function automatic logic [5:0] month_offset(input logic [MONTH_W-1:0] m);
      logic [5:0] o;
      case (m)
         4'd0:    o = 6'd25;
         4'd1:    o = 6'd28;
         4'd2:    o = 6'd31;
         4'd3:    o = 6'd2;
         4'd4:    o = 6'd5;
         4'd5:    o = 6'd7;
         4'd6:    o = 6'd10;
         4'd7:    o = 6'd12;
         4'd8:    o = 6'd15;
         4'd9:    o = 6'd18;
         4'd10:   o = 6'd20;
         4'd11:   o = 6'd23;
         4'd12:   o = 6'd25;
         4'd13:   o = 6'd28;
         4'd14:   o = 6'd31;
         default: o = 6'd33;
      endcase
      return o;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cda_div25.sv =====
// quotient of a 12-bit value by 25 through a reciprocal multiply
`default_nettype none

module cda_div25
   import cda_pkg::*;
(
   input  wire logic [DIVD_W-1:0] dividend,
   output logic      [QUOT_W-1:0] quotient
);

   logic [PROD_W-1:0] product;

   assign product  = {{(PROD_W-DIVD_W){1'b0}}, dividend} * PROD_W'(RECIP_25);
   assign quotient = product[RECIP_SHIFT +: QUOT_W];

endmodule

`default_nettype wire

// ===== hw/rtl/calendar_date_analyzer.sv =====
// top level: four-stage pipeline from a date to weekday, calendar counts and next date
//
//   channel | ports           | direction | payload
//   --------+-----------------+-----------+------------------------------------------
//   request | req_tvalid/tready/tdata | in  | one date: day, month, year
//   result  | rsp_tvalid/tready/tdata | out | one analysis per date
//
// a date passes the registers of stages 1 to 4 before its result turns valid;
// one date can enter every cycle unless the result channel stalls. stage 1
// holds the two divide-by-25 multipliers, stage 2 the leap test and weekday
// sum, stage 3 the mod-7 fold and day of year, stage 4 the output register.
// each stage holds its contents while the stage after it is full and stalled,
// so a stall drops nothing. reset clears the stage valid bits only.
`default_nettype none

module calendar_date_analyzer
   import cda_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // day [4:0], month [8:5], year [22:9], zero [23]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // weekday [2:0], is_end_of_week [3], is_weekend [4], is_business_day [5],
   // month_length [10:6], days_to_week_end [13:11], days_to_month_end [18:14],
   // day_of_year [27:19], days_to_year_end [36:28], next_day [41:37],
   // next_month [45:42], next_year [59:46], zero [63:60]
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   // stall chain
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;

   assign s4_ready   = !rsp_valid_ff || rsp_tready;
   assign s3_ready   = !s3_valid_ff || s4_ready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   // stage 1: year split and quotients by 25
   logic [DAY_W-1:0]   in_day;
   logic [MONTH_W-1:0] in_month;
   logic [YEAR_W-1:0]  in_year;
   logic               shift_in;
   logic               neg_in;
   logic [YEAR_W-1:0]  adj_year_in;
   logic [QUOT_W-1:0]  q_year_in;
   logic [QUOT_W-1:0]  q_adj_in;

   assign in_day   = req_tdata[DAY_W-1:0];
   assign in_month = req_tdata[DAY_W +: MONTH_W];
   assign in_year  = req_tdata[DAY_W+MONTH_W +: YEAR_W];

   always_comb begin
      shift_in = (in_month <= MONTH_FEB);
      // year zero in january or february steps back to year minus one
      neg_in   = shift_in && (in_year == '0);
      if (neg_in) begin
         adj_year_in = '0;
      end else begin
         adj_year_in = in_year - YEAR_W'(shift_in);
      end
   end

   cda_div25 u_div_year (
      .dividend (in_year[YEAR_W-1:2]),
      .quotient (q_year_in)
   );

   cda_div25 u_div_adj (
      .dividend (adj_year_in[YEAR_W-1:2]),
      .quotient (q_adj_in)
   );

   logic [DAY_W-1:0]   s1_day_ff;
   logic [MONTH_W-1:0] s1_month_ff;
   logic [YEAR_W-1:0]  s1_year_ff;
   logic [YEAR_W-1:0]  s1_adj_year_ff;
   logic               s1_neg_ff;
   logic [QUOT_W-1:0]  s1_q_year_ff;
   logic [QUOT_W-1:0]  s1_q_adj_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_tvalid) begin
         s1_day_ff      <= in_day;
         s1_month_ff    <= in_month;
         s1_year_ff     <= in_year;
         s1_adj_year_ff <= adj_year_in;
         s1_neg_ff      <= neg_in;
         s1_q_year_ff   <= q_year_in;
         s1_q_adj_ff    <= q_adj_in;
      end
   end

   // stage 2: leap test, month length, weekday sum
   logic [DIVD_W-1:0] q_year_x25;
   logic              leap_in;
   logic [DAY_W-1:0]  month_len_in;
   logic [SUM_W-1:0]  year_term;
   logic [SUM_W-1:0]  sum_in;

   always_comb begin
      q_year_x25 = {{(DIVD_W-QUOT_W){1'b0}}, s1_q_year_ff} * DIVD_W'(25);
      // multiple of 4, and not of 100 unless also of 400
      leap_in = (s1_year_ff[1:0] == 2'b00) &&
                ((q_year_x25 != s1_year_ff[YEAR_W-1:2]) || (s1_year_ff[3:2] == 2'b00));
      if (s1_month_ff == MONTH_FEB) begin
         month_len_in = leap_in ? FEB_LEAP_DAYS : FEB_DAYS;
      end else begin
         month_len_in = month_days_base(s1_month_ff);
      end
      // y + y/4 - y/100 + y/400, with y/100 = (y/4)/25 and y/400 = (y/100)/4
      year_term = SUM_W'(s1_adj_year_ff)
                + SUM_W'(s1_adj_year_ff[YEAR_W-1:2])
                - SUM_W'(s1_q_adj_ff)
                + SUM_W'(s1_q_adj_ff[QUOT_W-1:2]);
      sum_in = SUM_W'(s1_day_ff) + SUM_W'(month_offset(s1_month_ff)) + year_term
             - SUM_W'(s1_neg_ff);
   end

   logic [DAY_W-1:0]   s2_day_ff;
   logic [MONTH_W-1:0] s2_month_ff;
   logic [YEAR_W-1:0]  s2_year_ff;
   logic               s2_leap_ff;
   logic [DAY_W-1:0]   s2_month_len_ff;
   logic [SUM_W-1:0]   s2_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_day_ff       <= s1_day_ff;
         s2_month_ff     <= s1_month_ff;
         s2_year_ff      <= s1_year_ff;
         s2_leap_ff      <= leap_in;
         s2_month_len_ff <= month_len_in;
         s2_sum_ff       <= sum_in;
      end
   end

   // stage 3: mod 7, day of year, next date
   logic [5:0]         digit_sum;
   logic [3:0]         fold;
   logic [WDAY_W-1:0]  weekday_in;
   logic [DOY_W-1:0]   doy_in;
   logic [DAY_W-1:0]   next_day_in;
   logic [MONTH_W-1:0] next_month_in;
   logic [YEAR_W-1:0]  next_year_in;

   always_comb begin
      // 8 is 1 mod 7, so octal digits add up to the same residue
      digit_sum = 6'(s2_sum_ff[2:0]) + 6'(s2_sum_ff[5:3]) + 6'(s2_sum_ff[8:6])
                + 6'(s2_sum_ff[11:9]) + 6'(s2_sum_ff[14:12]);
      fold      = 4'(digit_sum[5:3]) + 4'(digit_sum[2:0]);
      if (fold >= 4'd7) begin
         weekday_in = WDAY_W'(fold - 4'd7);
      end else begin
         weekday_in = WDAY_W'(fold);
      end

      doy_in = DOY_W'(s2_day_ff) + days_before_month(s2_month_ff)
             + DOY_W'(s2_leap_ff && (s2_month_ff >= MONTH_MAR));

      next_day_in   = s2_day_ff + 5'd1;
      next_month_in = s2_month_ff;
      next_year_in  = s2_year_ff;
      if (s2_day_ff == s2_month_len_ff) begin
         next_day_in = 5'd1;
         if (s2_month_ff == MONTH_DEC) begin
            next_month_in = MONTH_JAN;
            next_year_in  = s2_year_ff + 14'd1;
         end else begin
            next_month_in = s2_month_ff + 4'd1;
         end
      end
   end

   logic [WDAY_W-1:0]  s3_weekday_ff;
   logic [DAY_W-1:0]   s3_day_ff;
   logic [DAY_W-1:0]   s3_month_len_ff;
   logic               s3_leap_ff;
   logic [DOY_W-1:0]   s3_doy_ff;
   logic [DAY_W-1:0]   s3_next_day_ff;
   logic [MONTH_W-1:0] s3_next_month_ff;
   logic [YEAR_W-1:0]  s3_next_year_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_weekday_ff    <= weekday_in;
         s3_day_ff        <= s2_day_ff;
         s3_month_len_ff  <= s2_month_len_ff;
         s3_leap_ff       <= s2_leap_ff;
         s3_doy_ff        <= doy_in;
         s3_next_day_ff   <= next_day_in;
         s3_next_month_ff <= next_month_in;
         s3_next_year_ff  <= next_year_in;
      end
   end

   // stage 4: flags, remaining-day counts, output register
   rsp_type          rsp_in;
   logic [DOY_W-1:0] year_len;

   always_comb begin
      year_len              = s3_leap_ff ? LEAP_YEAR_DAYS : YEAR_DAYS;
      rsp_in.weekday        = s3_weekday_ff;
      rsp_in.is_end_of_week = (s3_weekday_ff == WDAY_SATURDAY);
      rsp_in.is_weekend     = (s3_weekday_ff == WDAY_SATURDAY) ||
                              (s3_weekday_ff == WDAY_FRIDAY);
      rsp_in.is_business_day = !rsp_in.is_weekend;
      rsp_in.month_length    = s3_month_len_ff;
      rsp_in.days_to_week_end = WDAY_SATURDAY - s3_weekday_ff;
      if (s3_month_len_ff > s3_day_ff) begin
         rsp_in.days_to_month_end = s3_month_len_ff - s3_day_ff;
      end else begin
         rsp_in.days_to_month_end = '0;
      end
      rsp_in.day_of_year = s3_doy_ff;
      if (year_len > s3_doy_ff) begin
         rsp_in.days_to_year_end = year_len - s3_doy_ff;
      end else begin
         rsp_in.days_to_year_end = '0;
      end
      rsp_in.next_day   = s3_next_day_ff;
      rsp_in.next_month = s3_next_month_ff;
      rsp_in.next_year  = s3_next_year_ff;
   end

   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready && s3_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-$bits(rsp_type)){1'b0}}, rsp_ff};

endmodule

`default_nettype wire
